[hw/rtl/gcm_pkg.sv]
// Shared types and constants for the greedy capacitated matcher.
package gcm_pkg;

  localparam int unsigned MaxParticipants = 64;
  localparam int unsigned MaxDishes       = 32;

  localparam int unsigned RowW     = 32;
  localparam int unsigned DishW    = 5;
  localparam int unsigned PartW    = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned DishCntW = 6;
  localparam int unsigned CapW     = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  localparam logic [DishCntW-1:0] DishCountRst = DishCntW'(32);
  localparam logic [CapW-1:0]     DishCapRst   = CapW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgDishCount    = 2'd0,
    CfgDishCapacity = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StAlloc,
    StScanRd,
    StScanChk,
    StFinish,
    StEmit
  } state_e;

  typedef struct packed {
    logic            start_new;
    logic [RowW-1:0] accept_row;
  } in_t;

  typedef struct packed {
    logic              matched;
    logic [DishW-1:0]  own_dish;
    logic              displaced;
    logic [PartW-1:0]  displaced_participant;
    logic [DishW-1:0]  displaced_new_dish;
    logic [CountW-1:0] matched_total;
    logic              row_dropped;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] wdata;
  } cfg_t;

endpackage

[hw/rtl/gcm_stream_if.sv]
// Valid/ready channel carrying one payload of type T.
interface gcm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/gcm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/gcm_pick.sv]
// Priority pick: lowest candidate dish, and lowest candidate dish with capacity.
module gcm_pick #(
  parameter int unsigned N  = 32,
  parameter int unsigned IW = 5
) (
  input  logic [N-1:0]  cand_i,
  input  logic [N-1:0]  avail_i,
  output logic          any_o,
  output logic [IW-1:0] any_idx_o,
  output logic          free_o,
  output logic [IW-1:0] free_idx_o
);
  always_comb begin
    any_o      = 1'b0;
    any_idx_o  = '0;
    free_o     = 1'b0;
    free_idx_o = '0;
    // walk downward so the lowest hit wins
    for (int j = N - 1; j >= 0; j--) begin
      if (cand_i[j]) begin
        any_o     = 1'b1;
        any_idx_o = IW'(j);
      end
      if (cand_i[j] && avail_i[j]) begin
        free_o     = 1'b1;
        free_idx_o = IW'(j);
      end
    end
  end
endmodule

[hw/rtl/greedy_capacitated_matcher.sv]
// Top level of the greedy capacitated matcher with one-step displacement.
// Steps: idle takes the input, allocation picks a dish; a dropped row, a free dish or no
// usable dish go straight to emit. Otherwise a displacement search reads each earlier row
// (one RAM read, then one pick each); on success a finish step hands the row the target.
// Throughput: one item at a time; new input is taken only after the result is registered.
// Reset: count and row index cleared, capacities 1, dish_count 32, stores undefined.
module greedy_capacitated_matcher #(
  parameter int unsigned MAX_PARTICIPANTS = gcm_pkg::MaxParticipants,
  parameter int unsigned MAX_DISHES       = gcm_pkg::MaxDishes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gcm_stream_if.sink   in_i,
  gcm_stream_if.source out_o,
  gcm_stream_if.sink   cfg_i
);
  // Dishes actually tracked: mask rows are 32 bits wide.
  localparam int unsigned DishN    = (MAX_DISHES < 32) ? MAX_DISHES : 32;
  localparam int unsigned DishIdxW = (DishN > 1) ? $clog2(DishN) : 1;
  localparam int unsigned PartIdxW = (MAX_PARTICIPANTS > 1) ? $clog2(MAX_PARTICIPANTS) : 1;
  localparam int unsigned AsgW     = DishIdxW + 1;  // holds bit + dish

  localparam int unsigned CapW   = gcm_pkg::CapW;
  localparam int unsigned CountW = gcm_pkg::CountW;

  // ---------------------------------------------------------------------------
  // Configuration registers; the port is always ready.
  // ---------------------------------------------------------------------------
  logic [gcm_pkg::DishCntW-1:0] dish_count_q;
  logic [CapW-1:0]              dish_cap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dish_count_q <= gcm_pkg::DishCountRst;
      dish_cap_q   <= gcm_pkg::DishCapRst;
    end else if (cfg_i.valid) begin
      unique case (gcm_pkg::cfg_reg_e'(cfg_i.data.reg_idx))
        gcm_pkg::CfgDishCount:    dish_count_q <= cfg_i.data.wdata[gcm_pkg::DishCntW-1:0];
        gcm_pkg::CfgDishCapacity: dish_cap_q   <= cfg_i.data.wdata;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  gcm_pkg::state_e state_q, state_d;

  logic [CapW-1:0]     cap_q [DishN];
  logic [CapW-1:0]     cap_d [DishN];
  logic [CountW-1:0]   count_q, count_d;
  logic [PartIdxW:0]   idx_q, idx_d;     // next free row slot, can reach the depth
  logic [PartIdxW-1:0] cur_q, cur_d;     // slot of the row in flight
  logic [PartIdxW-1:0] k_q, k_d;         // displacement scan pointer
  logic [DishIdxW-1:0] target_q, target_d;
  logic [31:0]         row_q, row_d;
  gcm_pkg::out_t       res_q, res_d;
  gcm_pkg::out_t       out_q;
  logic                out_valid_q;

  // Stores: acceptance rows and held dish per participant.
  logic                acc_we;
  logic [31:0]         acc_rdata;
  logic                asg_we;
  logic [PartIdxW-1:0] asg_waddr;
  logic [AsgW-1:0]     asg_wdata;
  logic [AsgW-1:0]     asg_rdata;

  gcm_ram #(
    .WIDTH (32),
    .DEPTH (MAX_PARTICIPANTS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (idx_q[PartIdxW-1:0]),
    .wdata_i (row_q),
    .raddr_i (k_q),
    .rdata_o (acc_rdata)
  );

  gcm_ram #(
    .WIDTH (AsgW),
    .DEPTH (MAX_PARTICIPANTS)
  ) u_asg_ram (
    .clk_i   (clk_i),
    .we_i    (asg_we),
    .waddr_i (asg_waddr),
    .wdata_i (asg_wdata),
    .raddr_i (k_q),
    .rdata_o (asg_rdata)
  );

  // ---------------------------------------------------------------------------
  // Dish masks and the shared pick unit. The pick sees the new row during
  // allocation and a stored row during the displacement scan.
  // ---------------------------------------------------------------------------
  logic [DishN-1:0]    act_mask;
  logic [DishN-1:0]    avail;
  logic [DishN-1:0]    cand;
  logic                any_found, free_found;
  logic [DishIdxW-1:0] any_idx, free_idx;

  always_comb begin
    for (int j = 0; j < DishN; j++) begin
      act_mask[j] = int'(dish_count_q) > j;
      avail[j]    = cap_q[j] != '0;
    end
  end

  assign cand = (state_q == gcm_pkg::StAlloc) ? (row_q[DishN-1:0] & act_mask)
                                              : (acc_rdata[DishN-1:0] & act_mask);

  gcm_pick #(
    .N  (DishN),
    .IW (DishIdxW)
  ) u_pick (
    .cand_i     (cand),
    .avail_i    (avail),
    .any_o      (any_found),
    .any_idx_o  (any_idx),
    .free_o     (free_found),
    .free_idx_o (free_idx)
  );

  // Saturating match count.
  logic [CountW-1:0] count_inc;
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

  logic cap_reload, cap_dec;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_load;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    k_d        = k_q;
    target_d   = target_q;
    row_d      = row_q;
    res_d      = res_q;
    acc_we     = 1'b0;
    asg_we     = 1'b0;
    asg_waddr  = cur_q;
    asg_wdata  = {1'b1, target_q};
    cap_reload = 1'b0;
    cap_dec    = 1'b0;
    out_load   = 1'b0;
    in_i.ready = 1'b0;

    unique case (state_q)
      gcm_pkg::StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          row_d = in_i.data.accept_row;
          if (in_i.data.start_new) begin
            cap_reload = 1'b1;
            count_d    = '0;
            idx_d      = '0;
          end
          state_d = gcm_pkg::StAlloc;
        end
      end

      gcm_pkg::StAlloc: begin
        res_d               = '0;
        res_d.matched_total = count_q;
        if (idx_q == (PartIdxW + 1)'(MAX_PARTICIPANTS)) begin
          res_d.row_dropped = 1'b1;
          state_d           = gcm_pkg::StEmit;
        end else begin
          cur_d     = idx_q[PartIdxW-1:0];
          idx_d     = idx_q + 1'b1;
          acc_we    = 1'b1;
          asg_we    = 1'b1;
          asg_waddr = idx_q[PartIdxW-1:0];
          if (free_found) begin
            asg_wdata           = {1'b1, free_idx};
            cap_dec             = 1'b1;
            count_d             = count_inc;
            res_d.matched       = 1'b1;
            res_d.own_dish      = gcm_pkg::DishW'(free_idx);
            res_d.matched_total = count_inc;
            state_d             = gcm_pkg::StEmit;
          end else begin
            // not held yet; a successful displacement rewrites it
            asg_wdata = {1'b0, any_idx};
            target_d  = any_idx;
            k_d       = '0;
            state_d   = any_found ? gcm_pkg::StScanRd : gcm_pkg::StEmit;
          end
        end
      end

      gcm_pkg::StScanRd: begin
        // stores are read at k_q; data is back next cycle
        state_d = (k_q == cur_q) ? gcm_pkg::StEmit : gcm_pkg::StScanChk;
      end

      gcm_pkg::StScanChk: begin
        if (asg_rdata[AsgW-1] && asg_rdata[DishIdxW-1:0] == target_q && free_found) begin
          asg_we                      = 1'b1;
          asg_waddr                   = k_q;
          asg_wdata                   = {1'b1, free_idx};
          cap_dec                     = 1'b1;
          count_d                     = count_inc;
          res_d.matched               = 1'b1;
          res_d.own_dish              = gcm_pkg::DishW'(target_q);
          res_d.displaced             = 1'b1;
          res_d.displaced_participant = gcm_pkg::PartW'(k_q);
          res_d.displaced_new_dish    = gcm_pkg::DishW'(free_idx);
          res_d.matched_total         = count_inc;
          state_d                     = gcm_pkg::StFinish;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = gcm_pkg::StScanRd;
        end
      end

      gcm_pkg::StFinish: begin
        // current participant takes the freed target slot
        asg_we    = 1'b1;
        asg_waddr = cur_q;
        asg_wdata = {1'b1, target_q};
        state_d   = gcm_pkg::StEmit;
      end

      gcm_pkg::StEmit: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = gcm_pkg::StIdle;
        end
      end

      default: state_d = gcm_pkg::StIdle;
    endcase
  end

  // Capacity update: reload on start, one decrement per grant.
  always_comb begin
    for (int j = 0; j < DishN; j++) begin
      if (cap_reload) begin
        cap_d[j] = dish_cap_q;
      end else if (cap_dec && free_idx == DishIdxW'(j)) begin
        cap_d[j] = cap_q[j] - 1'b1;
      end else begin
        cap_d[j] = cap_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcm_pkg::StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < DishN; j++) begin
        cap_q[j] <= gcm_pkg::DishCapRst;
      end
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      cap_q   <= cap_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    k_q      <= k_d;
    target_q <= target_d;
    row_q    <= row_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
endmodule
